// File: design/hlr_pkg.sv
// Shared types, constants and helpers of the horizontal line resampler.
package hlr_pkg;

	localparam int unsigned DEF_MAX_LINE         = 4096;
	localparam int unsigned DEF_MAX_TAP_MULT     = 8;
	localparam int unsigned DEF_WEIGHT_FRAC_BITS = 14;
	localparam int unsigned QUEUE_DEPTH          = 4;

	localparam logic [1:0] REG_SOURCE_WIDTH    = 2'd0;
	localparam logic [1:0] REG_DEST_WIDTH      = 2'd1;
	localparam logic [1:0] REG_COMPONENT_COUNT = 2'd2;
	localparam logic [1:0] REG_KERNEL_MODE     = 2'd3;

	localparam logic KERNEL_CATMULL_ROM = 1'b1;

	typedef enum logic {
		CMD_LOAD    = 1'b0,
		CMD_COMPUTE = 1'b1
	} cmd_t;

	typedef struct packed {
		logic [12:0] source_width;
		logic [12:0] dest_width;
		logic [2:0]  component_count;
		logic        kernel_mode;
	} cfg_t;

	typedef struct packed {
		cmd_t        command;
		logic [11:0] position;
		logic [31:0] pixel;
	} item_t;

	typedef struct packed {
		logic start;
	} div_ctl_t;

	typedef struct packed {
		logic busy;
		logic done;
	} div_stat_t;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_MULT,
		ST_NUM,
		ST_BASE,
		ST_FRAC,
		ST_TAP_D,
		ST_TAP_A,
		ST_TAP_SQ,
		ST_TAP_CU,
		ST_TAP_P,
		ST_TAP_W,
		ST_TAP_ACC,
		ST_EMIT
	} back_state_t;

	function automatic int max_int(input int a, input int b);
		return (a > b) ? a : b;
	endfunction

endpackage

// File: design/hlr_div.sv
// Restoring divider that produces one quotient bit per cycle.
module hlr_div import hlr_pkg::*; #(
	parameter int DIV_W = 30,
	parameter int DVS_W = 14
) (
	input  logic             clk,
	input  logic             arst_n,
	input  div_ctl_t         ctl,
	input  logic [DIV_W-1:0] dividend,
	input  logic [DVS_W-1:0] divisor,
	output div_stat_t        stat,
	output logic [DIV_W-1:0] quotient,
	output logic [DVS_W-1:0] remainder
);

	localparam int CW = $clog2(DIV_W + 1);

	logic             busy_q;
	logic             done_q;
	logic [CW-1:0]    cnt_q;
	logic [DIV_W-1:0] quo_q;
	logic [DVS_W-1:0] rem_q;
	logic [DVS_W-1:0] dvs_q;
	logic [DVS_W:0]   shifted;
	logic [DVS_W:0]   diff;
	logic             ge;

	assign shifted = {rem_q, quo_q[DIV_W-1]};
	assign ge      = shifted >= {1'b0, dvs_q};
	assign diff    = shifted - {1'b0, dvs_q};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (ctl.start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(DIV_W);
			end else if (busy_q) begin
				cnt_q <= cnt_q - CW'(1);
				if (cnt_q == CW'(1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			quo_q <= dividend;
			rem_q <= '0;
			dvs_q <= divisor;
		end else if (busy_q) begin
			quo_q <= {quo_q[DIV_W-2:0], ge};
			rem_q <= ge ? diff[DVS_W-1:0] : shifted[DVS_W-1:0];
		end
	end

	assign stat.busy = busy_q;
	assign stat.done = done_q;
	assign quotient  = quo_q;
	assign remainder = rem_q;

endmodule

// File: design/hlr_front.sv
// Front end: configuration registers, item intake, classification and queue.
module hlr_front import hlr_pkg::*; #(
	parameter int MAX_LINE = DEF_MAX_LINE
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] position,
	input  logic [7:0]  in_c0,
	input  logic [7:0]  in_c1,
	input  logic [7:0]  in_c2,
	input  logic [7:0]  in_c3,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data,
	output cfg_t        cfg,
	output logic        q_valid,
	input  logic        q_ready,
	output item_t       q_item
);

	localparam int PW = $clog2(QUEUE_DEPTH);
	localparam int NW = $clog2(QUEUE_DEPTH + 1);

	cfg_t          cfg_q;
	item_t         fifo_q [QUEUE_DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [NW-1:0] count_q;
	logic          accept;
	logic          push;
	logic          pop;
	item_t         new_item;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.source_width    <= 13'd1;
			cfg_q.dest_width      <= 13'd1;
			cfg_q.component_count <= 3'd3;
			cfg_q.kernel_mode     <= KERNEL_CATMULL_ROM;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_SOURCE_WIDTH:    cfg_q.source_width    <= cfg_data;
				REG_DEST_WIDTH:      cfg_q.dest_width      <= cfg_data;
				REG_COMPONENT_COUNT: cfg_q.component_count <= cfg_data[2:0];
				REG_KERNEL_MODE:     cfg_q.kernel_mode     <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign cfg = cfg_q;

	// Loads that fall outside the line store are dropped here.
	assign in_ready = count_q != NW'(QUEUE_DEPTH);
	assign accept   = in_valid && in_ready;
	assign push     = accept && (command == CMD_COMPUTE || 32'(position) < 32'(MAX_LINE));
	assign q_valid  = count_q != '0;
	assign pop      = q_valid && q_ready;

	assign new_item.command  = cmd_t'(command);
	assign new_item.position = position;
	assign new_item.pixel    = {in_c3, in_c2, in_c1, in_c0};

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PW'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + NW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - NW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			fifo_q[wr_ptr_q] <= new_item;
		end
	end

	assign q_item = fifo_q[rd_ptr_q];

endmodule

// File: design/hlr_back.sv
// Back end: line store, position mapping, tap sequencer, accumulation and output register.
module hlr_back import hlr_pkg::*; #(
	parameter int MAX_LINE         = DEF_MAX_LINE,
	parameter int MAX_TAP_MULT     = DEF_MAX_TAP_MULT,
	parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  cfg_t        cfg,
	input  logic        q_valid,
	output logic        q_ready,
	input  item_t       q_item,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] out_index,
	output logic [7:0]  out_c0,
	output logic [7:0]  out_c1,
	output logic [7:0]  out_c2,
	output logic [7:0]  out_c3
);

	localparam int F     = WEIGHT_FRAC_BITS;
	localparam int AW    = $clog2(MAX_LINE);
	localparam int SRC_W = $clog2(MAX_LINE + 1);
	localparam int MW    = $clog2(MAX_TAP_MULT + 1);
	localparam int TW    = $clog2(4 * MAX_TAP_MULT + 1);
	localparam int WW    = TW + 1;
	localparam int NUM_W = 14 + SRC_W;
	localparam int IW    = NUM_W + 1;
	localparam int D_W   = 16 + $clog2(2 * MAX_TAP_MULT + 1);
	localparam int P_W   = 26;
	localparam int WD_W  = F + 10;
	localparam int WT_W  = F + 2;
	localparam int SUM_W = F + 11 + TW;
	localparam int DIV_W = max_int(max_int(NUM_W, 30), max_int(D_W, WD_W));
	localparam int DVS_W = max_int(14, $clog2(6 * MAX_TAP_MULT + 1));

	back_state_t             state_q;
	back_state_t             state_d;
	logic [31:0]             mem [MAX_LINE];
	logic [11:0]             pos_q;
	logic [SRC_W-1:0]        src_q;
	logic [12:0]             dst_q;
	logic [2:0]              cmp_q;
	logic                    mode_q;
	logic [MW-1:0]           mult_q;
	logic [TW-1:0]           taps_q;
	logic signed [NUM_W-1:0] num_q;
	logic signed [NUM_W-1:0] base_q;
	logic [15:0]             tx_q;
	logic [TW-1:0]           j_q;
	logic signed [WW-1:0]    win_q;
	logic [17:0]             a_q;
	logic [18:0]             a2_q;
	logic [19:0]             a3_q;
	logic                    pneg_q;
	logic signed [WT_W-1:0]  w_q;
	logic [31:0]             px_q;
	logic signed [SUM_W-1:0] sum_q [4];
	logic                    out_valid_q;
	logic [11:0]             out_index_q;
	logic [7:0]              out_c_q [4];

	div_ctl_t                div_ctl;
	div_stat_t               div_stat;
	logic [DIV_W-1:0]        div_dividend;
	logic [DVS_W-1:0]        div_divisor;
	logic [DIV_W-1:0]        div_quo;
	logic [DVS_W-1:0]        div_rem;

	logic [SRC_W-1:0]        src_cfg;
	logic [12:0]             dst_cfg;
	logic [2:0]              cmp_cfg;
	logic [13:0]             twod;
	logic [MW-1:0]           mult_c;
	logic [13+SRC_W-1:0]     prod_c;
	logic signed [NUM_W-1:0] num_c;
	logic signed [NUM_W-1:0] rem_neg;
	logic signed [WW-1:0]    win_init;
	logic [WW-1:0]           win_mag;
	logic [D_W-1:0]          d16;
	logic signed [IW-1:0]    idx;
	logic [AW-1:0]           rd_addr;
	logic signed [P_W-1:0]   a_s;
	logic signed [P_W-1:0]   a2_s;
	logic signed [P_W-1:0]   a3_s;
	logic signed [P_W-1:0]   p_c;
	logic [P_W-1:0]          pabs;
	logic [P_W+F-1:0]        pscaled;
	logic [DVS_W-1:0]        kmult;
	logic                    emit;
	logic                    mem_we;

	hlr_div #(
		.DIV_W (DIV_W),
		.DVS_W (DVS_W)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.ctl       (div_ctl),
		.dividend  (div_dividend),
		.divisor   (div_divisor),
		.stat      (div_stat),
		.quotient  (div_quo),
		.remainder (div_rem)
	);

	always_comb begin
		if (cfg.source_width == 13'd0) begin
			src_cfg = SRC_W'(1);
		end else if (32'(cfg.source_width) > 32'(MAX_LINE)) begin
			src_cfg = SRC_W'(MAX_LINE);
		end else begin
			src_cfg = SRC_W'(cfg.source_width);
		end
		dst_cfg = (cfg.dest_width == 13'd0) ? 13'd1 : cfg.dest_width;
		if (cfg.component_count == 3'd0) begin
			cmp_cfg = 3'd1;
		end else if (cfg.component_count inside {[3'd5:3'd7]}) begin
			cmp_cfg = 3'd4;
		end else begin
			cmp_cfg = cfg.component_count;
		end
	end

	assign twod = {dst_q, 1'b0};

	always_comb begin
		if (div_quo > DIV_W'(MAX_TAP_MULT)) begin
			mult_c = MW'(MAX_TAP_MULT);
		end else if (div_quo == '0) begin
			mult_c = MW'(1);
		end else begin
			mult_c = div_quo[MW-1:0];
		end
	end

	assign prod_c   = (13+SRC_W)'({pos_q, 1'b1}) * (13+SRC_W)'(src_q);
	assign num_c    = $signed({1'b0, prod_c}) - $signed(NUM_W'(dst_q));
	assign rem_neg  = num_q + $signed(NUM_W'(twod));
	assign win_init = $signed(WW'(1)) - $signed({1'b0, taps_q >> 1});
	assign win_mag  = win_q[WW-1] ? WW'(-win_q) : WW'(win_q);

	always_comb begin
		if (win_q > $signed(WW'(0))) begin
			d16 = D_W'({win_mag, 16'h0000}) - D_W'(tx_q);
		end else begin
			d16 = D_W'({win_mag, 16'h0000}) + D_W'(tx_q);
		end
	end

	// Edge replication keeps every tap inside the loaded line.
	always_comb begin
		idx = $signed({base_q[NUM_W-1], base_q}) + IW'(win_q);
		if (idx < $signed(IW'(0))) begin
			rd_addr = '0;
		end else if (idx > $signed(IW'(src_q)) - $signed(IW'(1))) begin
			rd_addr = AW'(src_q - SRC_W'(1));
		end else begin
			rd_addr = idx[AW-1:0];
		end
	end

	assign a_s  = $signed(P_W'(a_q));
	assign a2_s = $signed(P_W'(a2_q));
	assign a3_s = $signed(P_W'(a3_q));

	always_comb begin
		if (mode_q != KERNEL_CATMULL_ROM) begin
			p_c = $signed(P_W'(65536)) - a_s;
		end else if (a_q < 18'd65536) begin
			p_c = $signed(P_W'(9)) * a3_s - $signed(P_W'(15)) * a2_s
				+ $signed(P_W'(393216));
		end else begin
			p_c = $signed(P_W'(15)) * a2_s - $signed(P_W'(3)) * a3_s
				- $signed(P_W'(24)) * a_s + $signed(P_W'(786432));
		end
		pabs    = p_c[P_W-1] ? P_W'(-p_c) : P_W'(p_c);
		pscaled = {pabs, {F{1'b0}}};
		kmult   = (mode_q == KERNEL_CATMULL_ROM) ? DVS_W'(mult_q) * DVS_W'(6)
			: DVS_W'(mult_q);
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (q_valid && q_item.command == CMD_COMPUTE) begin
					state_d = ST_MULT;
				end
			end
			ST_MULT:   if (div_stat.done) state_d = ST_NUM;
			ST_NUM:    state_d = num_q[NUM_W-1] ? ST_FRAC : ST_BASE;
			ST_BASE:   if (div_stat.done) state_d = ST_FRAC;
			ST_FRAC:   if (div_stat.done) state_d = ST_TAP_D;
			ST_TAP_D:  state_d = ST_TAP_A;
			ST_TAP_A:  if (div_stat.done) state_d = ST_TAP_SQ;
			ST_TAP_SQ: state_d = ST_TAP_CU;
			ST_TAP_CU: state_d = ST_TAP_P;
			ST_TAP_P:  state_d = ST_TAP_W;
			ST_TAP_W:  if (div_stat.done) state_d = ST_TAP_ACC;
			ST_TAP_ACC: begin
				state_d = (j_q == taps_q - TW'(1)) ? ST_EMIT : ST_TAP_D;
			end
			ST_EMIT:   if (!out_valid_q || out_ready) state_d = ST_IDLE;
			default:   state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		q_ready       = 1'b0;
		mem_we        = 1'b0;
		emit          = 1'b0;
		div_ctl.start = 1'b0;
		div_dividend  = '0;
		div_divisor   = '0;
		case (state_q)
			ST_IDLE: begin
				q_ready = 1'b1;
				if (q_valid && q_item.command == CMD_LOAD) begin
					mem_we = 1'b1;
				end
				if (q_valid && q_item.command == CMD_COMPUTE) begin
					div_ctl.start = 1'b1;
					div_dividend  = DIV_W'(src_cfg);
					div_divisor   = DVS_W'(dst_cfg);
				end
			end
			ST_NUM: begin
				div_ctl.start = 1'b1;
				div_divisor   = DVS_W'(twod);
				if (num_q[NUM_W-1]) begin
					div_dividend = DIV_W'({rem_neg[13:0], 16'h0000});
				end else begin
					div_dividend = DIV_W'(unsigned'(num_q));
				end
			end
			ST_BASE: begin
				div_ctl.start = div_stat.done;
				div_dividend  = DIV_W'({div_rem[13:0], 16'h0000});
				div_divisor   = DVS_W'(twod);
			end
			ST_TAP_D: begin
				div_ctl.start = 1'b1;
				div_dividend  = DIV_W'(d16);
				div_divisor   = DVS_W'(mult_q);
			end
			ST_TAP_P: begin
				div_ctl.start = 1'b1;
				div_dividend  = DIV_W'(pscaled[P_W+F-1:16]);
				div_divisor   = kmult;
			end
			ST_EMIT: begin
				emit = !out_valid_q || out_ready;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[AW'(q_item.position)] <= q_item.pixel;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_TAP_D) begin
			px_q <= mem[rd_addr];
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				pos_q  <= q_item.position;
				src_q  <= src_cfg;
				dst_q  <= dst_cfg;
				cmp_q  <= cmp_cfg;
				mode_q <= cfg.kernel_mode;
			end
			ST_MULT: begin
				mult_q <= mult_c;
				taps_q <= (mode_q == KERNEL_CATMULL_ROM) ? TW'({mult_c, 2'b00})
					: TW'({mult_c, 1'b0});
				num_q  <= num_c;
			end
			ST_NUM: begin
				if (num_q[NUM_W-1]) begin
					base_q <= -$signed(NUM_W'(1));
				end
			end
			ST_BASE: begin
				if (div_stat.done) begin
					base_q <= $signed(div_quo[NUM_W-1:0]);
				end
			end
			ST_FRAC: begin
				if (div_stat.done) begin
					tx_q  <= div_quo[15:0];
					j_q   <= '0;
					win_q <= win_init;
					for (int c = 0; c < 4; c++) begin
						sum_q[c] <= '0;
					end
				end
			end
			ST_TAP_A: begin
				if (div_stat.done) begin
					a_q <= div_quo[17:0];
				end
			end
			ST_TAP_SQ: a2_q <= 19'((36'(a_q) * 36'(a_q)) >> 16);
			ST_TAP_CU: a3_q <= 20'((37'(a2_q) * 37'(a_q)) >> 16);
			ST_TAP_P:  pneg_q <= p_c[P_W-1];
			ST_TAP_W: begin
				if (div_stat.done) begin
					w_q <= pneg_q ? -$signed({1'b0, div_quo[WT_W-2:0]})
						: $signed({1'b0, div_quo[WT_W-2:0]});
				end
			end
			ST_TAP_ACC: begin
				for (int c = 0; c < 4; c++) begin
					sum_q[c] <= sum_q[c] + SUM_W'(w_q)
						* SUM_W'($signed({1'b0, px_q[8*c +: 8]}));
				end
				j_q   <= j_q + TW'(1);
				win_q <= win_q + $signed(WW'(1));
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (emit) begin
			out_index_q <= pos_q;
			for (int c = 0; c < 4; c++) begin
				if (3'(c) >= cmp_q || sum_q[c] <= $signed(SUM_W'(0))) begin
					out_c_q[c] <= 8'd0;
				end else if (sum_q[c][SUM_W-1:F] > (SUM_W-F)'(255)) begin
					out_c_q[c] <= 8'd255;
				end else begin
					out_c_q[c] <= sum_q[c][F +: 8];
				end
			end
		end
	end

	assign out_valid = out_valid_q;
	assign out_index = out_index_q;
	assign out_c0    = out_c_q[0];
	assign out_c1    = out_c_q[1];
	assign out_c2    = out_c_q[2];
	assign out_c3    = out_c_q[3];

	a_mult_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP_D || state_q == ST_TAP_ACC || state_q == ST_EMIT)
		|-> (mult_q >= MW'(1) && mult_q <= MW'(MAX_TAP_MULT)))
		else $error("Tap multiplier out of range.");

	a_tap_count: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_TAP_D || state_q == ST_TAP_ACC) |-> (j_q < taps_q))
		else $error("Tap counter ran past the window.");

	a_div_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		div_ctl.start |-> !div_stat.busy)
		else $error("Divider started while busy.");

	a_emit_shows: assert property (@(posedge clk) disable iff (!arst_n)
		emit |=> out_valid_q)
		else $error("Result was not presented after emit.");

endmodule

// File: design/horizontal_line_resampler_top.sv
// Top level of the horizontal line resampler.
//
//   channel  direction  handshake             payload
//   input    in         in_valid / in_ready   command, position, in_c0..in_c3
//   result   out        out_valid / out_ready out_index, out_c0..out_c3
//   config   in         cfg_we                cfg_index, cfg_data
//
// A load is written to the line store straight from idle; a compute runs three divisions, or
// two when the mapped position lies left of the first pixel, plus two divisions per
// tap, where the window has 2 or 4 times the downscale multiplier taps. The shared
// divider is 30 bits wide by default and produces one quotient bit per cycle.
// Reset clears the queue, the sequencer and the output valid flag; the line store
// holds nothing defined until it is loaded.
// A four-entry queue lets intake continue while the back end or the output stalls.
module horizontal_line_resampler_top import hlr_pkg::*; #(
	parameter int MAX_LINE         = DEF_MAX_LINE,
	parameter int MAX_TAP_MULT     = DEF_MAX_TAP_MULT,
	parameter int WEIGHT_FRAC_BITS = DEF_WEIGHT_FRAC_BITS
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        command,
	input  logic [11:0] position,
	input  logic [7:0]  in_c0,
	input  logic [7:0]  in_c1,
	input  logic [7:0]  in_c2,
	input  logic [7:0]  in_c3,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [11:0] out_index,
	output logic [7:0]  out_c0,
	output logic [7:0]  out_c1,
	output logic [7:0]  out_c2,
	output logic [7:0]  out_c3,
	input  logic        cfg_we,
	input  logic [1:0]  cfg_index,
	input  logic [12:0] cfg_data
);

	cfg_t  cfg;
	logic  q_valid;
	logic  q_ready;
	item_t q_item;

	hlr_front #(
		.MAX_LINE (MAX_LINE)
	) u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.command   (command),
		.position  (position),
		.in_c0     (in_c0),
		.in_c1     (in_c1),
		.in_c2     (in_c2),
		.in_c3     (in_c3),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item)
	);

	hlr_back #(
		.MAX_LINE         (MAX_LINE),
		.MAX_TAP_MULT     (MAX_TAP_MULT),
		.WEIGHT_FRAC_BITS (WEIGHT_FRAC_BITS)
	) u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg       (cfg),
		.q_valid   (q_valid),
		.q_ready   (q_ready),
		.q_item    (q_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_index (out_index),
		.out_c0    (out_c0),
		.out_c1    (out_c1),
		.out_c2    (out_c2),
		.out_c3    (out_c3)
	);

endmodule
